/* hw/rtl/phong_specular_weight_core_assert.svh */
// Assertion macros shared by the specular weight RTL.
// Each macro expands to a labeled concurrent assertion in simulation
// and to nothing in synthesis.
`ifndef PHONG_SPECULAR_WEIGHT_CORE_ASSERT_SVH
`define PHONG_SPECULAR_WEIGHT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Overlapping implication: cons is checked from the cycle of ante.
`define PSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("psw: implication check failed");
// Next-cycle implication: cons is checked in the cycle after ante.
`define PSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("psw: next-cycle check failed");
`else
`define PSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/psw_pkg.sv */
`default_nettype none
package psw_pkg;

    // Fixed field widths
    localparam int VEC_W    = 16;
    localparam int COEF_W   = 16;
    localparam int SHIN_W   = 8;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_COEF_RED   = 2'd0;
    localparam logic [1:0] REG_COEF_GREEN = 2'd1;
    localparam logic [1:0] REG_COEF_BLUE  = 2'd2;
    localparam logic [1:0] REG_SHININESS  = 2'd3;

    // Register reset values
    localparam logic [COEF_W-1:0] COEF_RESET = 16'd16384;
    localparam logic [SHIN_W-1:0] SHIN_RESET = 8'd1;

    // Saturation limit of a colour weight
    localparam logic [COEF_W-1:0] COLOUR_MAX = 16'hFFFF;

    typedef struct packed {
        logic [COEF_W-1:0] coef_red;
        logic [COEF_W-1:0] coef_green;
        logic [COEF_W-1:0] coef_blue;
        logic [SHIN_W-1:0] shininess;
    } cfg_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } vec_t;

endpackage
`default_nettype wire

/* hw/rtl/psw_cfg.sv */
`default_nettype none
module psw_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [psw_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [psw_pkg::DATA_W-1:0]   pwdata,
    output logic      [psw_pkg::DATA_W-1:0]   prdata,
    output psw_pkg::cfg_t                     cfg
);

    psw_pkg::cfg_t cfg_reg;
    psw_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign wr_en = psel & penable & pwrite;

    // Decode the write request
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                psw_pkg::REG_COEF_RED:   cfg_next.coef_red   = pwdata[psw_pkg::COEF_W-1:0];
                psw_pkg::REG_COEF_GREEN: cfg_next.coef_green = pwdata[psw_pkg::COEF_W-1:0];
                psw_pkg::REG_COEF_BLUE:  cfg_next.coef_blue  = pwdata[psw_pkg::COEF_W-1:0];
                psw_pkg::REG_SHININESS:  cfg_next.shininess  = pwdata[psw_pkg::SHIN_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_red   <= psw_pkg::COEF_RESET;
            cfg_reg.coef_green <= psw_pkg::COEF_RESET;
            cfg_reg.coef_blue  <= psw_pkg::COEF_RESET;
            cfg_reg.shininess  <= psw_pkg::SHIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (paddr[3:2])
            psw_pkg::REG_COEF_RED:   prdata = 32'(cfg_reg.coef_red);
            psw_pkg::REG_COEF_GREEN: prdata = 32'(cfg_reg.coef_green);
            psw_pkg::REG_COEF_BLUE:  prdata = 32'(cfg_reg.coef_blue);
            psw_pkg::REG_SHININESS:  prdata = 32'(cfg_reg.shininess);
            default:                 prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* hw/rtl/psw_cos.sv */
`default_nettype none
module psw_cos #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 valid_in,
    input  wire psw_pkg::vec_t        normal,
    input  wire psw_pkg::vec_t        incoming,
    input  wire psw_pkg::vec_t        outgoing,
    output logic                      valid_out,
    output logic [FRAC_BITS:0]        c_out
);

    localparam int VW  = psw_pkg::VEC_W;
    localparam int PW  = FRAC_BITS + 1;
    localparam int DW  = 2 * VW + 2 - FRAC_BITS;
    localparam int NW  = DW + VW;
    localparam int RW  = FRAC_BITS + 3;
    localparam int OW  = RW + VW;
    localparam int SW  = OW + 2;
    localparam logic signed [63:0] RMAX = (64'sd1 <<< (FRAC_BITS + 2)) - 64'sd1;
    localparam logic signed [63:0] RMIN = -(64'sd1 <<< (FRAC_BITS + 2));
    localparam logic signed [63:0] CMAX = (64'sd1 <<< (FRAC_BITS + 1)) - 64'sd1;

    logic signed [VW-1:0]    n_in [3];
    logic signed [VW-1:0]    i_in [3];
    logic signed [VW-1:0]    o_in [3];

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [2*VW-1:0]  prod1_reg [3];
    logic signed [2*VW-1:0]  prod1_next [3];
    logic signed [VW-1:0]    n1_reg [3], i1_reg [3], o1_reg [3];
    logic signed [DW-1:0]    d2_reg, d2_next;
    logic signed [2*VW+1:0]  sum2;
    logic signed [VW-1:0]    n2_reg [3], i2_reg [3], o2_reg [3];
    logic signed [NW-1:0]    dn3_reg [3], dn3_next [3];
    logic signed [VW-1:0]    i3_reg [3], o3_reg [3];
    logic signed [RW-1:0]    r4_reg [3], r4_next [3];
    logic signed [VW-1:0]    o4_reg [3];
    logic signed [OW-1:0]    ro5_reg [3], ro5_next [3];
    logic signed [SW-1:0]    sum6;
    logic signed [63:0]      c_ext;
    logic [PW-1:0]           c6_reg, c6_next;

    assign n_in[0] = normal.x;
    assign n_in[1] = normal.y;
    assign n_in[2] = normal.z;
    assign i_in[0] = incoming.x;
    assign i_in[1] = incoming.y;
    assign i_in[2] = incoming.z;
    assign o_in[0] = outgoing.x;
    assign o_in[1] = outgoing.y;
    assign o_in[2] = outgoing.z;

    // Stage 1: products of the incoming direction and the normal
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod1_next[k] = (2*VW)'(i_in[k]) * (2*VW)'(n_in[k]);
        end
    end

    // Stage 2: sum and drop the fraction to get d
    assign sum2 = (2*VW+2)'(prod1_reg[0]) + (2*VW+2)'(prod1_reg[1])
                + (2*VW+2)'(prod1_reg[2]);
    assign d2_next = sum2[2*VW+1:FRAC_BITS];

    // Stage 3: d times each normal component
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dn3_next[k] = NW'(d2_reg) * NW'(n2_reg[k]);
        end
    end

    // Stage 4: reflect and saturate each component
    always_comb
    begin
        logic signed [63:0] t;
        logic signed [63:0] diff;
        for (int k = 0; k < 3; k++)
        begin
            t    = 64'(dn3_reg[k]) >>> (FRAC_BITS - 1);
            diff = 64'(i3_reg[k]) - t;
            if (diff > RMAX)
                r4_next[k] = RW'(RMAX);
            else if (diff < RMIN)
                r4_next[k] = RW'(RMIN);
            else
                r4_next[k] = RW'(diff);
        end
    end

    // Stage 5: products of the reflection and the outgoing direction
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ro5_next[k] = OW'(r4_reg[k]) * OW'(o4_reg[k]);
        end
    end

    // Stage 6: sum, drop the fraction and clamp the cosine
    assign sum6  = SW'(ro5_reg[0]) + SW'(ro5_reg[1]) + SW'(ro5_reg[2]);
    assign c_ext = 64'($signed(sum6[SW-1:FRAC_BITS]));

    always_comb
    begin
        if (c_ext < 64'sd0)
            c6_next = '0;
        else if (c_ext > CMAX)
            c6_next = PW'(CMAX);
        else
            c6_next = PW'(c_ext);
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod1_reg[k] <= prod1_next[k];
            n1_reg[k]    <= n_in[k];
            i1_reg[k]    <= i_in[k];
            o1_reg[k]    <= o_in[k];
            n2_reg[k]    <= n1_reg[k];
            i2_reg[k]    <= i1_reg[k];
            o2_reg[k]    <= o1_reg[k];
            dn3_reg[k]   <= dn3_next[k];
            i3_reg[k]    <= i2_reg[k];
            o3_reg[k]    <= o2_reg[k];
            r4_reg[k]    <= r4_next[k];
            o4_reg[k]    <= o3_reg[k];
            ro5_reg[k]   <= ro5_next[k];
        end
        d2_reg <= d2_next;
        c6_reg <= c6_next;
    end

    assign valid_out = v6_reg;
    assign c_out     = c6_reg;

endmodule
`default_nettype wire

/* hw/rtl/psw_pow.sv */
`default_nettype none
`include "phong_specular_weight_core_assert.svh"
module psw_pow #(
    parameter int FRAC_BITS = 14,
    parameter int EXP_BITS  = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         valid_in,
    input  wire logic [FRAC_BITS:0]           c_in,
    input  wire logic [psw_pkg::SHIN_W-1:0]   shininess,
    output logic                              valid_out,
    output logic [FRAC_BITS:0]                p_out
);

    localparam int PW = FRAC_BITS + 1;
    localparam logic [PW-1:0] ONE  = PW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] PMAX = {PW{1'b1}};

    logic [15:0]         exp_wide;
    logic [EXP_BITS-1:0] e;

    logic [PW-1:0] sq_reg    [EXP_BITS];
    logic [PW-1:0] c_sq_reg  [EXP_BITS];
    logic          v_sq_reg  [EXP_BITS];
    logic [PW-1:0] mul_reg   [EXP_BITS];
    logic [PW-1:0] c_mul_reg [EXP_BITS];
    logic          v_mul_reg [EXP_BITS];

    // Keep the low exponent bits
    assign exp_wide = 16'(shininess);
    assign e        = exp_wide[EXP_BITS-1:0];

    // One square stage and one multiply stage per exponent bit, MSB first
    for (genvar j = 0; j < EXP_BITS; j++)
    begin : g_bit
        localparam int BIT = EXP_BITS - 1 - j;
        logic [PW-1:0]   p_src;
        logic [PW-1:0]   c_src;
        logic            v_src;
        logic [2*PW-1:0] sq_full;
        logic [PW:0]     sq_shift;
        logic [PW-1:0]   sq_next;
        logic [2*PW-1:0] mul_full;
        logic [PW:0]     mul_shift;
        logic [PW-1:0]   mul_next;

        if (j == 0)
        begin : g_first
            assign p_src = ONE;
            assign c_src = c_in;
            assign v_src = valid_in;
        end
        else
        begin : g_rest
            assign p_src = mul_reg[j-1];
            assign c_src = c_mul_reg[j-1];
            assign v_src = v_mul_reg[j-1];
        end

        // Square and saturate
        assign sq_full  = (2*PW)'(p_src) * (2*PW)'(p_src);
        assign sq_shift = sq_full[2*PW-1:FRAC_BITS];
        assign sq_next  = sq_shift[PW] ? PMAX : sq_shift[PW-1:0];

        // Multiply by the cosine where the exponent bit is set
        assign mul_full  = (2*PW)'(sq_reg[j]) * (2*PW)'(c_sq_reg[j]);
        assign mul_shift = mul_full[2*PW-1:FRAC_BITS];
        assign mul_next  = !e[BIT] ? sq_reg[j]
                         : (mul_shift[PW] ? PMAX : mul_shift[PW-1:0]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_sq_reg[j]  <= 1'b0;
                v_mul_reg[j] <= 1'b0;
            end
            else
            begin
                v_sq_reg[j]  <= v_src;
                v_mul_reg[j] <= v_sq_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[j]    <= sq_next;
            c_sq_reg[j]  <= c_src;
            mul_reg[j]   <= mul_next;
            c_mul_reg[j] <= c_sq_reg[j];
        end
    end

    assign valid_out = v_mul_reg[EXP_BITS-1];
    assign p_out     = mul_reg[EXP_BITS-1];

    // A zero cosine yields either one or zero, whatever the exponent
    `PSW_ASSERT_IMP(a_zero_cos, clk, rst_n, valid_in && (c_in == '0), ##(2*EXP_BITS) (p_out == '0 || p_out == ONE))
    // Every item leaves after two stages per exponent bit
    `PSW_ASSERT_IMP(a_pow_latency, clk, rst_n, valid_in, ##(2*EXP_BITS) valid_out)

endmodule
`default_nettype wire

/* hw/rtl/psw_scale.sv */
`default_nettype none
`include "phong_specular_weight_core_assert.svh"
module psw_scale #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         valid_in,
    input  wire logic [FRAC_BITS:0]           p_in,
    input  wire psw_pkg::cfg_t                cfg,
    output logic                              done,
    output logic [psw_pkg::COEF_W-1:0]        colour_red,
    output logic [psw_pkg::COEF_W-1:0]        colour_green,
    output logic [psw_pkg::COEF_W-1:0]        colour_blue
);

    localparam int CW = psw_pkg::COEF_W;
    localparam int PW = FRAC_BITS + 1;
    localparam int MW = CW + PW;

    logic [CW-1:0] coef [3];
    logic [CW-1:0] colour_reg  [3];
    logic [CW-1:0] colour_next [3];
    logic          done_reg;

    assign coef[0] = cfg.coef_red;
    assign coef[1] = cfg.coef_green;
    assign coef[2] = cfg.coef_blue;

    // Scale each coefficient by the power and saturate
    always_comb
    begin
        logic [MW-1:0] prod;
        logic [CW:0]   shifted;
        for (int k = 0; k < 3; k++)
        begin
            prod           = MW'(coef[k]) * MW'(p_in);
            shifted        = prod[MW-1:FRAC_BITS];
            colour_next[k] = shifted[CW] ? psw_pkg::COLOUR_MAX : shifted[CW-1:0];
        end
    end

    // Drive the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_in;
    end

    // Hold the result
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            colour_reg[k] <= colour_next[k];
        end
    end

    assign done         = done_reg;
    assign colour_red   = colour_reg[0];
    assign colour_green = colour_reg[1];
    assign colour_blue  = colour_reg[2];

    // A zero power gives black on all channels
    `PSW_ASSERT_NEXT(a_zero_power, clk, rst_n, valid_in && (p_in == '0), (colour_red == '0 && colour_green == '0 && colour_blue == '0))

endmodule
`default_nettype wire

/* hw/rtl/phong_specular_weight_core.sv */
// Phong specular weight, fully pipelined.
// Throughput: one request per cycle; busy stays low and the result strobe done
// has no back pressure.
// Each result passes the six-stage reflect/cosine pipe, one square and one
// multiply stage per exponent bit, and the output register. Reset clears all
// valid bits and restores the registers.
`default_nettype none
`include "phong_specular_weight_core_assert.svh"
module phong_specular_weight_core #(
    parameter int FRAC_BITS = 14,
    parameter int EXP_BITS  = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [psw_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [psw_pkg::DATA_W-1:0]   pwdata,
    output logic      [psw_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [15:0]           normal_x,
    input  wire logic signed [15:0]           normal_y,
    input  wire logic signed [15:0]           normal_z,
    input  wire logic signed [15:0]           incoming_x,
    input  wire logic signed [15:0]           incoming_y,
    input  wire logic signed [15:0]           incoming_z,
    input  wire logic signed [15:0]           outgoing_x,
    input  wire logic signed [15:0]           outgoing_y,
    input  wire logic signed [15:0]           outgoing_z,
    output logic                              done,
    output logic [15:0]                       colour_red,
    output logic [15:0]                       colour_green,
    output logic [15:0]                       colour_blue
);

    localparam int LAT = 7 + 2 * EXP_BITS;

    psw_pkg::cfg_t     cfg;
    psw_pkg::vec_t     normal_v;
    psw_pkg::vec_t     incoming_v;
    psw_pkg::vec_t     outgoing_v;
    logic              accept;
    logic              cos_valid;
    logic [FRAC_BITS:0] cos_val;
    logic              pow_valid;
    logic [FRAC_BITS:0] pow_val;

    // Take a request every cycle
    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start & ~busy;

    assign normal_v.x   = normal_x;
    assign normal_v.y   = normal_y;
    assign normal_v.z   = normal_z;
    assign incoming_v.x = incoming_x;
    assign incoming_v.y = incoming_y;
    assign incoming_v.z = incoming_z;
    assign outgoing_v.x = outgoing_x;
    assign outgoing_v.y = outgoing_y;
    assign outgoing_v.z = outgoing_z;

    psw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    psw_cos #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .normal    (normal_v),
        .incoming  (incoming_v),
        .outgoing  (outgoing_v),
        .valid_out (cos_valid),
        .c_out     (cos_val)
    );

    psw_pow #(
        .FRAC_BITS (FRAC_BITS),
        .EXP_BITS  (EXP_BITS)
    ) u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (cos_valid),
        .c_in      (cos_val),
        .shininess (cfg.shininess),
        .valid_out (pow_valid),
        .p_out     (pow_val)
    );

    psw_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_in     (pow_valid),
        .p_in         (pow_val),
        .cfg          (cfg),
        .done         (done),
        .colour_red   (colour_red),
        .colour_green (colour_green),
        .colour_blue  (colour_blue)
    );

    // Every accepted request comes out after the full pipeline latency
    `PSW_ASSERT_IMP(a_core_latency, clk, rst_n, accept, ##(LAT) done)

endmodule
`default_nettype wire

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 14;
    localparam int EXP_BITS = 8;
    localparam int LATENCY = 7 + 2 * EXP_BITS;
    localparam longint ONE = 64'sd1 << FRAC_BITS;
    localparam longint P_MAX = (64'sd1 << (FRAC_BITS + 1)) - 1;
    localparam longint R_LIM = 64'sd1 << (FRAC_BITS + 2);
    localparam longint WEIGHT_LIM = 65535;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_COUNT = 8;
    localparam int ITEMS_PER_PHASE = 135;

    typedef struct packed {
        psw_pkg::vec_t nrm;
        psw_pkg::vec_t inc;
        psw_pkg::vec_t outg;
    } shade_req_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } weight_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [psw_pkg::ADDR_W-1:0] paddr = '0;
    logic [psw_pkg::DATA_W-1:0] pwdata = '0;
    logic [psw_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    shade_req_t req_bus = '0;
    logic done;
    logic [15:0] colour_red;
    logic [15:0] colour_green;
    logic [15:0] colour_blue;

    psw_pkg::cfg_t shade_cfg;
    weight_t pending_weights[$];
    int mismatch_count = 0;

    phong_specular_weight_core #(
        .FRAC_BITS(FRAC_BITS),
        .EXP_BITS(EXP_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .busy(busy),
        .normal_x(req_bus.nrm.x),
        .normal_y(req_bus.nrm.y),
        .normal_z(req_bus.nrm.z),
        .incoming_x(req_bus.inc.x),
        .incoming_y(req_bus.inc.y),
        .incoming_z(req_bus.inc.z),
        .outgoing_x(req_bus.outg.x),
        .outgoing_y(req_bus.outg.y),
        .outgoing_z(req_bus.outg.z),
        .done(done),
        .colour_red(colour_red),
        .colour_green(colour_green),
        .colour_blue(colour_blue)
    );

    always #1 clk = ~clk;

    // Give up if the run hangs
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // Fixed-point product of two non-negative values, floored and saturated
    function automatic longint qmul_sat(input longint a, input longint b, input longint hi);
        longint r;
        r = (a * b) >>> FRAC_BITS;
        return (r > hi) ? hi : r;
    endfunction

    // Mirror the incoming direction about the normal, components saturated
    function automatic void reflect_dir(input psw_pkg::vec_t nrm, input psw_pkg::vec_t inc,
                                        output longint rx, output longint ry,
                                        output longint rz);
        longint nx, ny, nz, ix, iy, iz, dot;
        nx = nrm.x;
        ny = nrm.y;
        nz = nrm.z;
        ix = inc.x;
        iy = inc.y;
        iz = inc.z;
        dot = (ix * nx + iy * ny + iz * nz) >>> FRAC_BITS;
        rx = clamp(ix - ((2 * dot * nx) >>> FRAC_BITS), -R_LIM, R_LIM - 1);
        ry = clamp(iy - ((2 * dot * ny) >>> FRAC_BITS), -R_LIM, R_LIM - 1);
        rz = clamp(iz - ((2 * dot * nz) >>> FRAC_BITS), -R_LIM, R_LIM - 1);
    endfunction

    function automatic weight_t predict_weights(input shade_req_t q);
        longint rx, ry, rz, ox, oy, oz, cosv, pw;
        weight_t w;
        reflect_dir(q.nrm, q.inc, rx, ry, rz);
        ox = q.outg.x;
        oy = q.outg.y;
        oz = q.outg.z;
        cosv = clamp((rx * ox + ry * oy + rz * oz) >>> FRAC_BITS, 0, P_MAX);
        // Square-and-multiply from the top exponent bit down
        pw = ONE;
        for (int k = EXP_BITS - 1; k >= 0; k--)
        begin
            pw = qmul_sat(pw, pw, P_MAX);
            if (shade_cfg.shininess[k])
                pw = qmul_sat(pw, cosv, P_MAX);
        end
        w.red = 16'(qmul_sat(longint'(shade_cfg.coef_red), pw, WEIGHT_LIM));
        w.green = 16'(qmul_sat(longint'(shade_cfg.coef_green), pw, WEIGHT_LIM));
        w.blue = 16'(qmul_sat(longint'(shade_cfg.coef_blue), pw, WEIGHT_LIM));
        return w;
    endfunction

    function automatic logic [31:0] register_value(input logic [1:0] idx);
        case (idx)
            psw_pkg::REG_COEF_RED: return 32'(shade_cfg.coef_red);
            psw_pkg::REG_COEF_GREEN: return 32'(shade_cfg.coef_green);
            psw_pkg::REG_COEF_BLUE: return 32'(shade_cfg.coef_blue);
            psw_pkg::REG_SHININESS: return 32'(shade_cfg.shininess);
            default: return 32'd0;
        endcase
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s expected %h got %h", name, want, got));
    endfunction

    function automatic psw_pkg::vec_t make_vec(input int x, input int y, input int z);
        psw_pkg::vec_t v;
        v.x = 16'(x);
        v.y = 16'(y);
        v.z = 16'(z);
        return v;
    endfunction

    function automatic shade_req_t make_req(input psw_pkg::vec_t nrm, input psw_pkg::vec_t inc,
                                            input psw_pkg::vec_t outg);
        shade_req_t q;
        q.nrm = nrm;
        q.inc = inc;
        q.outg = outg;
        return q;
    endfunction

    // Mostly in the unit range, sometimes any 16-bit pattern
    function automatic logic signed [15:0] rand_comp();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic psw_pkg::vec_t rand_unit();
        real ax, ay, az, len;
        ax = real'(int'($urandom_range(0, 2000)) - 1000);
        ay = real'(int'($urandom_range(0, 2000)) - 1000);
        az = real'(int'($urandom_range(0, 2000)) - 1000);
        len = $sqrt(ax * ax + ay * ay + az * az);
        if (len < 1.0)
        begin
            ax = 1000.0;
            len = 1000.0;
        end
        return make_vec($rtoi(ax * 16384.0 / len), $rtoi(ay * 16384.0 / len),
                        $rtoi(az * 16384.0 / len));
    endfunction

    function automatic logic signed [15:0] near_comp(input longint base, input int spread);
        longint v;
        v = base + longint'($urandom_range(0, 2 * spread)) - spread;
        return 16'(clamp(v, -32768, 32767));
    endfunction

    // Viewer close to the mirror direction, so the cosine sits near one
    function automatic shade_req_t mirror_request();
        shade_req_t q;
        longint rx, ry, rz;
        int spread;
        q.nrm = rand_unit();
        q.inc = rand_unit();
        reflect_dir(q.nrm, q.inc, rx, ry, rz);
        spread = ($urandom_range(0, 3) == 0) ? 2000 : 64;
        q.outg.x = near_comp(rx, spread);
        q.outg.y = near_comp(ry, spread);
        q.outg.z = near_comp(rz, spread);
        return q;
    endfunction

    function automatic shade_req_t random_request();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return mirror_request();
        if (pick < 17)
            return make_req(rand_unit(), rand_unit(), rand_unit());
        return make_req(make_vec(rand_comp(), rand_comp(), rand_comp()),
                        make_vec(rand_comp(), rand_comp(), rand_comp()),
                        make_vec(rand_comp(), rand_comp(), rand_comp()));
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_request(input shade_req_t q, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus <= q;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        pending_weights.push_back(predict_weights(q));
    endtask

    // Write one register once the pipe has drained, then read it back
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        start <= 1'b0;
        while (pending_weights.size() != 0) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= psw_pkg::ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            psw_pkg::REG_COEF_RED: shade_cfg.coef_red = value[psw_pkg::COEF_W-1:0];
            psw_pkg::REG_COEF_GREEN: shade_cfg.coef_green = value[psw_pkg::COEF_W-1:0];
            psw_pkg::REG_COEF_BLUE: shade_cfg.coef_blue = value[psw_pkg::COEF_W-1:0];
            psw_pkg::REG_SHININESS: shade_cfg.shininess = value[psw_pkg::SHIN_W-1:0];
            default: ;
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== register_value(idx))
            note_mismatch($sformatf("register %0d read %h expected %h",
                                    idx, readback, register_value(idx)));
    endtask

    task automatic apply_config(input psw_pkg::cfg_t cfg);
        write_register(psw_pkg::REG_COEF_RED, 32'(cfg.coef_red));
        write_register(psw_pkg::REG_COEF_GREEN, 32'(cfg.coef_green));
        write_register(psw_pkg::REG_COEF_BLUE, 32'(cfg.coef_blue));
        write_register(psw_pkg::REG_SHININESS, 32'(cfg.shininess));
    endtask

    // Compare each result strobe with the oldest outstanding request
    always @(posedge clk)
    begin : weight_check
        weight_t want;
        if (rst_n && done)
        begin
            if (pending_weights.size() == 0)
                note_mismatch($sformatf("weights %h/%h/%h with no request outstanding",
                                        colour_red, colour_green, colour_blue));
            else
            begin
                want = pending_weights.pop_front();
                check_field("colour_red", want.red, colour_red);
                check_field("colour_green", want.green, colour_green);
                check_field("colour_blue", want.blue, colour_blue);
            end
        end
    end

    // Reset values: unit coefficients, linear cosine
    task automatic test_reset_defaults();
        send_request(make_req(make_vec(0, 0, 16384), make_vec(0, 0, -16384),
                              make_vec(0, 0, 16384)), 0);
        send_request(mirror_request(), 0);
        send_request(random_request(), 1);
    endtask

    // Extreme vectors: saturated reflection, negative and oversized cosine
    task automatic test_corner_vectors();
        send_request(make_req(make_vec(0, 0, 0), make_vec(0, 0, 0), make_vec(0, 0, 0)), 0);
        apply_config('{coef_red: 16'hFFFF, coef_green: 16'hFFFF, coef_blue: 16'hFFFF,
                       shininess: 8'd1});
        send_request(make_req(make_vec(16384, 16384, 16384), make_vec(16384, 16384, 16384),
                              make_vec(16384, 16384, 16384)), 0);
        send_request(make_req(make_vec(16384, 16384, 16384),
                              make_vec(-16384, -16384, -16384),
                              make_vec(16384, 16384, 16384)), 0);
        send_request(make_req(make_vec(-32768, -32768, -32768),
                              make_vec(-32768, -32768, -32768),
                              make_vec(-32768, -32768, -32768)), 0);
        send_request(make_req(make_vec(32767, 32767, 32767), make_vec(32767, 32767, 32767),
                              make_vec(32767, 32767, 32767)), 2);
        send_request(make_req(make_vec(0, 0, 16384), make_vec(0, 0, -16384),
                              make_vec(0, 0, 16384)), 0);
        send_request(make_req(make_vec(-16384, 0, 0), make_vec(16384, -16384, 0),
                              make_vec(-16384, -16384, 0)), 0);
        send_request(make_req(make_vec(16'h5555, 16'hAAAA, 16'h5555),
                              make_vec(16'hAAAA, 16'h5555, 16'hAAAA),
                              make_vec(16'h5555, 16'hAAAA, 16'h5555)), 1);
        send_request(make_req(make_vec(16'hAAAA, 16'h5555, 16'hAAAA),
                              make_vec(16'h5555, 16'hAAAA, 16'h5555),
                              make_vec(16'hAAAA, 16'h5555, 16'hAAAA)), 0);
    endtask

    // Zero, full and single-bit exponents around a cosine of one
    task automatic test_exponent_edges();
        psw_pkg::vec_t up, down;
        up = make_vec(0, 0, 16384);
        down = make_vec(0, 0, -16384);
        write_register(psw_pkg::REG_SHININESS, 32'd0);
        send_request(make_req(make_vec(0, 0, 0), make_vec(0, 0, 0), make_vec(0, 0, 0)), 0);
        send_request(make_req(up, down, down), 0);
        write_register(psw_pkg::REG_SHININESS, 32'd255);
        send_request(make_req(up, down, up), 0);
        send_request(make_req(up, down, make_vec(0, 0, 16383)), 0);
        send_request(make_req(up, down, make_vec(0, 0, 16400)), 0);
        write_register(psw_pkg::REG_SHININESS, 32'd128);
        send_request(make_req(up, down, make_vec(0, 0, 16000)), 0);
        apply_config('{coef_red: 16'd0, coef_green: 16'd1, coef_blue: 16'd16384,
                       shininess: 8'd2});
        send_request(make_req(up, down, make_vec(0, 300, 16380)), 0);
    endtask

    // Random requests across several register settings
    task automatic test_random_phases();
        psw_pkg::cfg_t cfg;
        bit burst;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            cfg.coef_red = 16'($urandom);
            cfg.coef_green = 16'($urandom);
            cfg.coef_blue = 16'($urandom);
            cfg.shininess = 8'($urandom);
            case (phase)
                0: cfg = '{psw_pkg::COEF_RESET, psw_pkg::COEF_RESET, psw_pkg::COEF_RESET,
                           psw_pkg::SHIN_RESET};
                1: cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255};
                2: cfg = '{16'd0, 16'd0, 16'd0, 8'd0};
                3: cfg.shininess = 8'd0;
                4: cfg.shininess = 8'($urandom_range(2, 8));
                5: cfg = '{16'hFFFF, 16'd0, psw_pkg::COEF_RESET, 8'd128};
                default: ;
            endcase
            apply_config(cfg);
            burst = 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Alternate stretches of back-to-back requests with gapped ones
                if (n % 32 == 0)
                    burst = ($urandom_range(0, 2) == 0);
                send_request(random_request(), burst ? 0 : rand_gap());
            end
        end
    endtask

    initial
    begin
        shade_cfg = '{psw_pkg::COEF_RESET, psw_pkg::COEF_RESET, psw_pkg::COEF_RESET,
                      psw_pkg::SHIN_RESET};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_corner_vectors();
        test_exponent_edges();
        test_random_phases();
        start <= 1'b0;
        // Drain the pipe, then watch for stray strobes
        while (pending_weights.size() != 0) @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* phong_specular_weight_core.f */
+incdir+hw/rtl
hw/rtl/psw_pkg.sv
hw/rtl/psw_cfg.sv
hw/rtl/psw_cos.sv
hw/rtl/psw_pow.sv
hw/rtl/psw_scale.sv
hw/rtl/phong_specular_weight_core.sv
dv/testbench.sv
